@@ rtl/gede_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gede_pkg
// Shared types and constants for the gas exposure dose alarm: field widths,
// register map, band codes, reset values and the rescale unit interface.
// ----------------------------------------------------------------------------
package gede_pkg;

  // Field and state widths
  localparam int COUNT_WIDTH     = 32;
  localparam int PPM_WIDTH       = 16;
  localparam int THR_WIDTH       = 16;
  localparam int LIMIT_WIDTH     = 32;
  localparam int OUT_COUNT_WIDTH = 32;

  // APB register port
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 5;
  localparam int REG_IDX_WIDTH  = 3;

  // Rescale unit step counter, one bit per cycle
  localparam int STEP_WIDTH = $clog2(COUNT_WIDTH);
  localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(COUNT_WIDTH - 1);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // Register map, word index
  typedef enum logic [REG_IDX_WIDTH-1:0] {
    REG_ENABLE     = 3'd0,
    REG_THR_LOW    = 3'd1,
    REG_THR_MID    = 3'd2,
    REG_THR_HIGH   = 3'd3,
    REG_LIMIT_LOW  = 3'd4,
    REG_LIMIT_MID  = 3'd5,
    REG_LIMIT_HIGH = 3'd6
  } reg_idx_e;

  // Concentration bands
  typedef enum logic [1:0] {
    BAND_NONE = 2'd0,
    BAND_LOW  = 2'd1,
    BAND_MID  = 2'd2,
    BAND_HIGH = 2'd3
  } band_e;

  // Register reset values (thresholds are ppm in 12.4: 10, 25, 90 ppm)
  localparam logic                   RST_ENABLE     = 1'b1;
  localparam logic [THR_WIDTH-1:0]   RST_THR_LOW    = THR_WIDTH'(10 * 16);
  localparam logic [THR_WIDTH-1:0]   RST_THR_MID    = THR_WIDTH'(25 * 16);
  localparam logic [THR_WIDTH-1:0]   RST_THR_HIGH   = THR_WIDTH'(90 * 16);
  localparam logic [LIMIT_WIDTH-1:0] RST_LIMIT_LOW  = LIMIT_WIDTH'(60 * 60 * 8);
  localparam logic [LIMIT_WIDTH-1:0] RST_LIMIT_MID  = LIMIT_WIDTH'(60 * 60);
  localparam logic [LIMIT_WIDTH-1:0] RST_LIMIT_HIGH = LIMIT_WIDTH'(60 * 15);

  // Rescale request: floor(c * n / d), saturated
  typedef struct packed {
    logic                   start;
    logic [COUNT_WIDTH-1:0] c;
    logic [COUNT_WIDTH-1:0] n;
    logic [COUNT_WIDTH-1:0] d;
  } rs_req_t;

  typedef struct packed {
    logic                   done;
    logic [COUNT_WIDTH-1:0] quot;
  } rs_rsp_t;

endpackage

@@ rtl/gas_exposure_dose_alarm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_exposure_dose_alarm
// Sorts each one-second concentration tick into a band, tracks one exposure
// counter per band with rescaling on band change, and flags over-limit dose.
// ----------------------------------------------------------------------------
// Flow: a tick taken while disabled or below the low band goes straight to the emit
// state; with the band unchanged it passes the increment state first; on a band
// change the bit-serial rescale unit (32 multiply steps, then up to 32 divide steps)
// runs before the increment. One tick is in work at a time; the next is taken in the
// cycle after the result enters the output register, which may still be waiting.
// Reset: counters and band mark clear, registers take their documented values.
module gas_exposure_dose_alarm (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Input tick channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [gede_pkg::PPM_WIDTH-1:0]        ppm_level_i,
  // Result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [1:0]                            band_o,
  output logic [gede_pkg::OUT_COUNT_WIDTH-1:0]  exposure_count_o,
  output logic                                  alarm_o,
  // APB register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [gede_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  logic [gede_pkg::APB_DATA_WIDTH-1:0]   pwdata,
  output logic [gede_pkg::APB_DATA_WIDTH-1:0]   prdata,
  output logic                                  pready
);
  import gede_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RESCALE,
    ST_INC,
    ST_EMIT
  } state_e;

  // Configuration registers
  logic                   enable_q;
  logic [THR_WIDTH-1:0]   thr_low_q;
  logic [THR_WIDTH-1:0]   thr_mid_q;
  logic [THR_WIDTH-1:0]   thr_high_q;
  logic [LIMIT_WIDTH-1:0] limit_low_q;
  logic [LIMIT_WIDTH-1:0] limit_mid_q;
  logic [LIMIT_WIDTH-1:0] limit_high_q;

  logic                     wr_en;
  logic [REG_IDX_WIDTH-1:0] reg_idx;

  // Tracking state and datapath
  state_e                  state_q;
  logic [COUNT_WIDTH-1:0]  cnt_low_q;
  logic [COUNT_WIDTH-1:0]  cnt_mid_q;
  logic [COUNT_WIDTH-1:0]  cnt_high_q;
  band_e                   last_band_q;
  band_e                   band_q;
  logic [COUNT_WIDTH-1:0]  work_q;
  logic [COUNT_WIDTH-1:0]  res_count_q;
  logic                    res_alarm_q;
  rs_req_t                 req_q;
  rs_rsp_t                 rsp;
  logic                    out_valid_q;
  band_e                   out_band_q;
  logic [COUNT_WIDTH-1:0]  out_count_q;
  logic                    out_alarm_q;

  logic                    in_accept;
  logic                    out_free;
  logic                    rescale_go;
  band_e                   band_in;
  logic [COUNT_WIDTH-1:0]  cnt_in;
  logic [COUNT_WIDTH-1:0]  cnt_last;
  logic [LIMIT_WIDTH-1:0]  lim_in;
  logic [LIMIT_WIDTH-1:0]  lim_last;
  logic [LIMIT_WIDTH-1:0]  lim_cur;
  logic [COUNT_WIDTH-1:0]  inc_val;
  logic                    alarm_new;

  // APB decode
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[APB_ADDR_WIDTH-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= RST_ENABLE;
      thr_low_q    <= RST_THR_LOW;
      thr_mid_q    <= RST_THR_MID;
      thr_high_q   <= RST_THR_HIGH;
      limit_low_q  <= RST_LIMIT_LOW;
      limit_mid_q  <= RST_LIMIT_MID;
      limit_high_q <= RST_LIMIT_HIGH;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ENABLE:     enable_q     <= pwdata[0];
        REG_THR_LOW:    thr_low_q    <= pwdata[THR_WIDTH-1:0];
        REG_THR_MID:    thr_mid_q    <= pwdata[THR_WIDTH-1:0];
        REG_THR_HIGH:   thr_high_q   <= pwdata[THR_WIDTH-1:0];
        REG_LIMIT_LOW:  limit_low_q  <= pwdata[LIMIT_WIDTH-1:0];
        REG_LIMIT_MID:  limit_mid_q  <= pwdata[LIMIT_WIDTH-1:0];
        REG_LIMIT_HIGH: limit_high_q <= pwdata[LIMIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_ENABLE:     prdata = APB_DATA_WIDTH'(enable_q);
      REG_THR_LOW:    prdata = APB_DATA_WIDTH'(thr_low_q);
      REG_THR_MID:    prdata = APB_DATA_WIDTH'(thr_mid_q);
      REG_THR_HIGH:   prdata = APB_DATA_WIDTH'(thr_high_q);
      REG_LIMIT_LOW:  prdata = APB_DATA_WIDTH'(limit_low_q);
      REG_LIMIT_MID:  prdata = APB_DATA_WIDTH'(limit_mid_q);
      REG_LIMIT_HIGH: prdata = APB_DATA_WIDTH'(limit_high_q);
      default:        prdata = '0;
    endcase
  end

  // Band sort, highest passing threshold wins
  always_comb begin
    if (ppm_level_i > PPM_WIDTH'(thr_high_q)) begin
      band_in = BAND_HIGH;
    end else if (ppm_level_i > PPM_WIDTH'(thr_mid_q)) begin
      band_in = BAND_MID;
    end else if (ppm_level_i > PPM_WIDTH'(thr_low_q)) begin
      band_in = BAND_LOW;
    end else begin
      band_in = BAND_NONE;
    end
  end

  // Counter and limit selection by band
  always_comb begin
    case (band_in)
      BAND_LOW:  begin cnt_in = cnt_low_q;  lim_in = limit_low_q;  end
      BAND_MID:  begin cnt_in = cnt_mid_q;  lim_in = limit_mid_q;  end
      BAND_HIGH: begin cnt_in = cnt_high_q; lim_in = limit_high_q; end
      default:   begin cnt_in = '0;         lim_in = '0;           end
    endcase
    case (last_band_q)
      BAND_LOW:  begin cnt_last = cnt_low_q;  lim_last = limit_low_q;  end
      BAND_MID:  begin cnt_last = cnt_mid_q;  lim_last = limit_mid_q;  end
      BAND_HIGH: begin cnt_last = cnt_high_q; lim_last = limit_high_q; end
      default:   begin cnt_last = '0;         lim_last = '0;           end
    endcase
    case (band_q)
      BAND_LOW:  lim_cur = limit_low_q;
      BAND_MID:  lim_cur = limit_mid_q;
      BAND_HIGH: lim_cur = limit_high_q;
      default:   lim_cur = '0;
    endcase
  end

  // Saturating one-second increment and limit check
  assign inc_val   = (work_q == CNT_MAX) ? work_q : work_q + COUNT_WIDTH'(1);
  assign alarm_new = inc_val > COUNT_WIDTH'(lim_cur);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  // Band change with tracking on: the new counter needs a rescale
  assign rescale_go = in_accept & enable_q & (band_in != BAND_NONE) &
                      (last_band_q != BAND_NONE) & (last_band_q != band_in);

  gede_rescale u_rescale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  // Tick sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_low_q   <= '0;
      cnt_mid_q   <= '0;
      cnt_high_q  <= '0;
      last_band_q <= BAND_NONE;
      band_q      <= BAND_NONE;
      work_q      <= '0;
      res_count_q <= '0;
      res_alarm_q <= 1'b0;
      req_q       <= '0;
      out_valid_q <= 1'b0;
      out_band_q  <= BAND_NONE;
      out_count_q <= '0;
      out_alarm_q <= 1'b0;
    end else begin
      // Result register: loaded by the sequencer, cleared once taken downstream
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      req_q.start <= rescale_go;

      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            band_q <= band_in;
            if (!enable_q) begin
              // Frozen: report stored counter, no alarm
              res_count_q <= cnt_in;
              res_alarm_q <= 1'b0;
              state_q     <= ST_EMIT;
            end else if (band_in == BAND_NONE) begin
              // Clean air clears the dose, band mark stays
              cnt_low_q   <= '0;
              cnt_mid_q   <= '0;
              cnt_high_q  <= '0;
              res_count_q <= '0;
              res_alarm_q <= 1'b0;
              state_q     <= ST_EMIT;
            end else if (last_band_q != BAND_NONE && last_band_q != band_in) begin
              req_q.c     <= cnt_last;
              req_q.n     <= COUNT_WIDTH'(lim_in);
              req_q.d     <= COUNT_WIDTH'(lim_last);
              state_q     <= ST_RESCALE;
            end else begin
              work_q  <= cnt_in;
              state_q <= ST_INC;
            end
          end
        end
        ST_RESCALE: begin
          if (rsp.done) begin
            work_q  <= rsp.quot;
            state_q <= ST_INC;
          end
        end
        ST_INC: begin
          case (band_q)
            BAND_LOW:  cnt_low_q  <= inc_val;
            BAND_MID:  cnt_mid_q  <= inc_val;
            BAND_HIGH: cnt_high_q <= inc_val;
            default: ;
          endcase
          last_band_q <= band_q;
          res_count_q <= inc_val;
          res_alarm_q <= alarm_new;
          state_q     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_band_q  <= band_q;
            out_count_q <= res_count_q;
            out_alarm_q <= res_alarm_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign band_o           = out_band_q;
  assign exposure_count_o = out_count_q[OUT_COUNT_WIDTH-1:0];
  assign alarm_o          = out_alarm_q;

endmodule

@@ rtl/gede_rescale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gede_rescale
// Bit-serial rescale unit: shift-add multiply, then restoring divide, one
// bit per cycle. Quotient saturates to all ones, also on a zero divisor.
// ----------------------------------------------------------------------------
module gede_rescale (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gede_pkg::rs_req_t req_i,
  output gede_pkg::rs_rsp_t rsp_o
);
  import gede_pkg::*;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_MUL,
    RS_CHK,
    RS_DIV,
    RS_DONE
  } rs_state_e;

  rs_state_e               state_q;
  logic [COUNT_WIDTH-1:0]  hi_q;    // product high half, then remainder
  logic [COUNT_WIDTH-1:0]  lo_q;    // multiplier bits, product low, quotient
  logic [COUNT_WIDTH-1:0]  c_q;
  logic [COUNT_WIDTH-1:0]  d_q;
  logic [STEP_WIDTH-1:0]   step_q;

  logic [COUNT_WIDTH:0]    mul_sum;
  logic [COUNT_WIDTH:0]    div_trial;
  logic                    div_ok;

  // One multiply step: add multiplicand into the high half on a set bit
  assign mul_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, c_q} : '0);

  // One divide step: remainder stays below the divisor, so 33 bits suffice
  assign div_trial = {hi_q, lo_q[COUNT_WIDTH-1]} - {1'b0, d_q};
  assign div_ok    = ~div_trial[COUNT_WIDTH];

  // Sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RS_IDLE;
      hi_q    <= '0;
      lo_q    <= '0;
      c_q     <= '0;
      d_q     <= '0;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        RS_IDLE: begin
          if (req_i.start) begin
            hi_q    <= '0;
            lo_q    <= req_i.n;
            c_q     <= req_i.c;
            d_q     <= req_i.d;
            step_q  <= '0;
            state_q <= RS_MUL;
          end
        end
        RS_MUL: begin
          hi_q   <= mul_sum[COUNT_WIDTH:1];
          lo_q   <= {mul_sum[0], lo_q[COUNT_WIDTH-1:1]};
          step_q <= step_q + STEP_WIDTH'(1);
          if (step_q == STEP_LAST) begin
            state_q <= RS_CHK;
          end
        end
        RS_CHK: begin
          // High half at or above the divisor: quotient overflows the counter
          step_q <= '0;
          if (hi_q >= d_q) begin
            lo_q    <= CNT_MAX;
            state_q <= RS_DONE;
          end else begin
            state_q <= RS_DIV;
          end
        end
        RS_DIV: begin
          hi_q   <= div_ok ? div_trial[COUNT_WIDTH-1:0]
                           : {hi_q[COUNT_WIDTH-2:0], lo_q[COUNT_WIDTH-1]};
          lo_q   <= {lo_q[COUNT_WIDTH-2:0], div_ok};
          step_q <= step_q + STEP_WIDTH'(1);
          if (step_q == STEP_LAST) begin
            state_q <= RS_DONE;
          end
        end
        RS_DONE: begin
          state_q <= RS_IDLE;
        end
        default: begin
          state_q <= RS_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done = (state_q == RS_DONE);
  assign rsp_o.quot = lo_q;

endmodule

@@ rtl/gede_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gede_checker
// Port-level checks for the gas exposure dose alarm, bound to the top level.
// ----------------------------------------------------------------------------
module gede_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic [1:0]                            band_o,
  input logic [gede_pkg::OUT_COUNT_WIDTH-1:0]  exposure_count_o,
  input logic                                  alarm_o
);
  import gede_pkg::*;

  // Below the low band there is no dose and no alarm
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && band_o == BAND_NONE) |-> (exposure_count_o == '0 && !alarm_o))
    else $error("band none with nonzero count or alarm");

  // An alarm needs a counter above its limit, so never a zero count
  a_alarm_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && alarm_o) |-> (exposure_count_o != '0))
    else $error("alarm with zero exposure count");

  // One tick in work: an accepted transaction blocks the input next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a transaction");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(band_o) && $stable(exposure_count_o) && $stable(alarm_o)))
    else $error("stalled result changed");

endmodule

bind gas_exposure_dose_alarm gede_checker u_gede_checker (.*);
